>>> rtl/lslf_pkg.sv
// Shared types and constants for the least-squares line fit block.
`default_nettype none

package lslf_pkg;

    // Fraction bits of the Q16.16 slope and intercept
    localparam int unsigned Q_FRAC = 16;
    // Quotient bits kept by the divider: 32 result bits plus one guard bit
    localparam int unsigned QUOT_W = 33;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // Requests from the top level to the fit engine
    typedef struct packed {
        logic start;   // last point accepted, sums are final
        logic take;    // result moved to the output register
    } lslf_ctrl_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic busy;    // fit in progress or result not yet taken
        logic done;    // result ready
    } lslf_status_t;

    // Fit result
    typedef struct packed {
        logic [31:0] slope;
        logic [31:0] intercept;
        logic        degenerate;
    } lslf_result_t;

endpackage

`default_nettype wire

>>> rtl/lslf_fit_engine.sv
// Sequential fit engine: shift-add products and restoring division on one adder.
`default_nettype none

module lslf_fit_engine #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned MAX_POINTS = 1024
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire lslf_pkg::lslf_ctrl_t                      ctrl,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0]           count,
    input  wire logic [COORD_BITS+$clog2(MAX_POINTS+1)-1:0]   sum_x,
    input  wire logic [COORD_BITS+$clog2(MAX_POINTS+1)-1:0]   sum_y,
    input  wire logic [2*COORD_BITS+$clog2(MAX_POINTS+1)-1:0] sum_xy,
    input  wire logic [2*COORD_BITS+$clog2(MAX_POINTS+1)-1:0] sum_xx,
    output lslf_pkg::lslf_status_t                         status,
    output lslf_pkg::lslf_result_t                         result
);
    import lslf_pkg::*;

    localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int unsigned SUM_W     = COORD_BITS + CNT_W;
    localparam int unsigned SQ_W      = 2 * COORD_BITS + CNT_W;
    localparam int unsigned ACC_W     = SUM_W + SQ_W + 2;
    localparam int unsigned DIV_STEPS = ACC_W + Q_FRAC;
    localparam int unsigned BIT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_EVAL = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_SAT  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PH_DEN   = 2'd0,
        PH_SLOPE = 2'd1,
        PH_INTER = 2'd2
    } phase_t;

    state_t              state_reg,     state_next;
    phase_t              phase_reg,     phase_next;
    logic                term_reg,      term_next;
    logic [BIT_W-1:0]    bit_cnt_reg,   bit_cnt_next;
    logic [ACC_W-1:0]    mcand_reg,     mcand_next;
    logic [SUM_W-1:0]    mplier_reg,    mplier_next;
    logic [ACC_W-1:0]    acc_reg,       acc_next;
    logic [ACC_W-1:0]    den_reg,       den_next;
    logic [ACC_W-1:0]    rem_reg,       rem_next;
    logic [QUOT_W-1:0]   quot_reg,      quot_next;
    logic                ovf_reg,       ovf_next;
    logic                neg_reg,       neg_next;
    logic [31:0]         slope_reg,     slope_next;
    logic [31:0]         intercept_reg, intercept_next;
    logic                degen_reg,     degen_next;

    logic [ACC_W-1:0]    add_a;
    logic [ACC_W-1:0]    add_b;
    logic                add_sub;
    logic [ACC_W-1:0]    add_sum;
    logic                mul_top;
    logic                div_last;
    logic [SUM_W-1:0]    sel_mplier;
    logic [ACC_W-1:0]    sel_mcand;
    logic [31:0]         sat_val;

    assign mul_top  = (bit_cnt_reg == BIT_W'(SUM_W - 1));
    assign div_last = (bit_cnt_reg == BIT_W'(DIV_STEPS - 1));

    // Pick the operand pair of the next product
    always_comb
    begin
        sel_mplier = {{(SUM_W-CNT_W){1'b0}}, count};
        sel_mcand  = {{(ACC_W-SQ_W){sum_xx[SQ_W-1]}}, sum_xx};
        case (phase_reg)
            PH_DEN:
            begin
                if (term_reg)
                begin
                    sel_mplier = sum_x;
                    sel_mcand  = {{(ACC_W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
                end
            end
            PH_SLOPE:
            begin
                if (term_reg)
                begin
                    sel_mplier = sum_x;
                    sel_mcand  = {{(ACC_W-SUM_W){sum_y[SUM_W-1]}}, sum_y};
                end
                else
                begin
                    sel_mcand  = {{(ACC_W-SQ_W){sum_xy[SQ_W-1]}}, sum_xy};
                end
            end
            default:
            begin
                if (term_reg)
                begin
                    sel_mplier = sum_x;
                    sel_mcand  = {{(ACC_W-SQ_W){sum_xy[SQ_W-1]}}, sum_xy};
                end
                else
                begin
                    sel_mplier = sum_y;
                end
            end
        endcase
    end

    // Shared adder: multiply steps, negation and trial subtraction
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_MUL:
            begin
                add_a = acc_reg;
                if (mplier_reg[0])
                begin
                    add_b   = mcand_reg;
                    // sign bit weighs negative; second term is subtracted
                    add_sub = mul_top ^ term_reg;
                end
            end
            ST_EVAL:
            begin
                add_b   = acc_reg;
                add_sub = 1'b1;
            end
            ST_DIV:
            begin
                add_a   = {rem_reg[ACC_W-2:0], acc_reg[ACC_W-1]};
                add_b   = den_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

    // Round toward zero is implicit; apply sign and saturate
    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || (quot_reg > {1'b0, SAT_NEG}))
                sat_val = SAT_NEG;
            else
                sat_val = 32'd0 - quot_reg[31:0];
        end
        else
        begin
            if (ovf_reg || quot_reg[QUOT_W-1] || quot_reg[31])
                sat_val = SAT_POS;
            else
                sat_val = quot_reg[31:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        term_next      = term_reg;
        bit_cnt_next   = bit_cnt_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        slope_next     = slope_reg;
        intercept_next = intercept_reg;
        degen_next     = degen_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    phase_next = PH_DEN;
                    term_next  = 1'b0;
                    acc_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mcand_next   = sel_mcand;
                mplier_next  = sel_mplier;
                bit_cnt_next = '0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next     = add_sum;
                mcand_next   = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next  = {1'b0, mplier_reg[SUM_W-1:1]};
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (mul_top)
                begin
                    if (!term_reg)
                    begin
                        term_next  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (phase_reg == PH_DEN)
                begin
                    den_next = acc_reg;
                    // all x equal or a single point: no fit
                    if (acc_reg[ACC_W-1] || (acc_reg == '0))
                    begin
                        degen_next     = 1'b1;
                        slope_next     = '0;
                        intercept_next = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        degen_next = 1'b0;
                        phase_next = PH_SLOPE;
                        term_next  = 1'b0;
                        acc_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    // take the magnitude of the numerator
                    neg_next = acc_reg[ACC_W-1];
                    if (acc_reg[ACC_W-1])
                        acc_next = add_sum;
                    rem_next     = '0;
                    quot_next    = '0;
                    ovf_next     = 1'b0;
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring step; zeros shifted in give the 2^16 scale
                if (!add_sum[ACC_W-1])
                    rem_next = add_sum;
                else
                    rem_next = {rem_reg[ACC_W-2:0], acc_reg[ACC_W-1]};
                acc_next     = {acc_reg[ACC_W-2:0], 1'b0};
                quot_next    = {quot_reg[QUOT_W-2:0], ~add_sum[ACC_W-1]};
                ovf_next     = ovf_reg | quot_reg[QUOT_W-1];
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (div_last)
                    state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (phase_reg == PH_SLOPE)
                begin
                    slope_next = sat_val;
                    phase_next = PH_INTER;
                    term_next  = 1'b0;
                    acc_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    intercept_next = sat_val;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctrl.take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        phase_reg     <= phase_next;
        term_reg      <= term_next;
        bit_cnt_reg   <= bit_cnt_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        acc_reg       <= acc_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        ovf_reg       <= ovf_next;
        neg_reg       <= neg_next;
        slope_reg     <= slope_next;
        intercept_reg <= intercept_next;
        degen_reg     <= degen_next;
    end

    assign status.busy       = (state_reg != ST_IDLE);
    assign status.done       = (state_reg == ST_DONE);
    assign result.slope      = slope_reg;
    assign result.intercept  = intercept_reg;
    assign result.degenerate = degen_reg;

endmodule

`default_nettype wire

>>> rtl/least_squares_line_fit_top.sv
// Top level of the least-squares line fit: point accumulation and result register.
`default_nettype none

// Takes (x, y) points one per transaction and keeps the count and the sums
// of x, y, x*y and x*x; a point that is not the last one is absorbed
// without a stall, and the next point is taken at once. A point marked
// last_point starts the fit: one shared adder builds by shift-add the two
// products of the denominator, then for the slope and then the intercept
// the two products of its numerator followed by a restoring division, one
// quotient bit per cycle. in_stall is high from the start of the fit until
// the result is taken into the output register. A degenerate run (all x
// equal or a single point) ends after the denominator. The result waits in
// an output register, so new points can already be taken while it sits
// unclaimed. Points beyond MAX_POINTS are dropped from the sums, but a
// last mark on them still starts the fit.

module least_squares_line_fit_top #(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire logic signed [COORD_BITS-1:0]          x_sample,
    input  wire logic signed [COORD_BITS-1:0]          y_sample,
    input  wire logic                                  last_point,
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic signed [31:0]                    slope,
    output      logic signed [31:0]                    intercept,
    output      logic                                  degenerate,
    output      logic [$clog2(MAX_POINTS+1)-1:0]       points_used
);
    import lslf_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned SUM_W = COORD_BITS + CNT_W;
    localparam int unsigned SQ_W  = 2 * COORD_BITS + CNT_W;

    logic [CNT_W-1:0]           count_reg,      count_next;
    logic [SUM_W-1:0]           sum_x_reg,      sum_x_next;
    logic [SUM_W-1:0]           sum_y_reg,      sum_y_next;
    logic [SQ_W-1:0]            sum_xy_reg,     sum_xy_next;
    logic [SQ_W-1:0]            sum_xx_reg,     sum_xx_next;
    logic                       out_valid_reg,  out_valid_next;
    logic [31:0]                slope_reg;
    logic [31:0]                intercept_reg;
    logic                       degen_reg;
    logic [CNT_W-1:0]           used_reg;

    logic signed [2*COORD_BITS-1:0] prod_xy;
    logic signed [2*COORD_BITS-1:0] prod_xx;
    logic                       accept;
    logic                       room;
    logic                       take;
    lslf_ctrl_t                 eng_ctrl;
    lslf_status_t               eng_status;
    lslf_result_t               eng_result;

    assign in_stall = eng_status.busy;
    assign accept   = in_valid && !in_stall;
    assign room     = (count_reg < CNT_W'(MAX_POINTS));
    assign take     = eng_status.done && (!out_valid_reg || !out_stall);

    assign prod_xy = x_sample * y_sample;
    assign prod_xx = x_sample * x_sample;

    // Advance the running sums, or clear them once the fit is handed off
    always_comb
    begin
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xy_next = sum_xy_reg;
        sum_xx_next = sum_xx_reg;
        if (take)
        begin
            count_next  = '0;
            sum_x_next  = '0;
            sum_y_next  = '0;
            sum_xy_next = '0;
            sum_xx_next = '0;
        end
        else if (accept && room)
        begin
            count_next  = count_reg + CNT_W'(1);
            sum_x_next  = sum_x_reg + {{(SUM_W-COORD_BITS){x_sample[COORD_BITS-1]}}, x_sample};
            sum_y_next  = sum_y_reg + {{(SUM_W-COORD_BITS){y_sample[COORD_BITS-1]}}, y_sample};
            sum_xy_next = sum_xy_reg
                        + {{(SQ_W-2*COORD_BITS){prod_xy[2*COORD_BITS-1]}}, prod_xy};
            sum_xx_next = sum_xx_reg
                        + {{(SQ_W-2*COORD_BITS){prod_xx[2*COORD_BITS-1]}}, prod_xx};
        end
    end

    // Output transaction: load on hand-off, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xy_reg    <= '0;
            sum_xx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_xy_reg    <= sum_xy_next;
            sum_xx_reg    <= sum_xx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slope_reg     <= eng_result.slope;
            intercept_reg <= eng_result.intercept;
            degen_reg     <= eng_result.degenerate;
            used_reg      <= count_reg;
        end
    end

    assign eng_ctrl.start = accept && last_point;
    assign eng_ctrl.take  = take;

    lslf_fit_engine #(
        .COORD_BITS (COORD_BITS),
        .MAX_POINTS (MAX_POINTS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (eng_ctrl),
        .count  (count_reg),
        .sum_x  (sum_x_reg),
        .sum_y  (sum_y_reg),
        .sum_xy (sum_xy_reg),
        .sum_xx (sum_xx_reg),
        .status (eng_status),
        .result (eng_result)
    );

    assign out_valid   = out_valid_reg;
    assign slope       = slope_reg;
    assign intercept   = intercept_reg;
    assign degenerate  = degen_reg;
    assign points_used = used_reg;

endmodule

`default_nettype wire

>>> rtl/lslf_checker.sv
// Port-level checker for the line fit top level, with its bind.
`default_nettype none

module lslf_checker #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             last_point,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [31:0]                      slope,
    input wire logic [31:0]                      intercept,
    input wire logic                             degenerate,
    input wire logic [$clog2(MAX_POINTS+1)-1:0]  points_used
);

    // A stalled result transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

    // A last point starts the fit, so input stalls on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_point |=> in_stall)
    else $error("input not stalled after last point");

    // A degenerate fit carries zero slope and intercept
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (slope == 32'd0) && (intercept == 32'd0))
    else $error("degenerate result with nonzero line");

    // Every fitted run has at least one point and at most the maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (points_used != '0)
                      && (points_used <= ($clog2(MAX_POINTS+1))'(MAX_POINTS)))
    else $error("points_used out of range");

endmodule

bind least_squares_line_fit_top lslf_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_lslf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_point  (last_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slope       (slope),
    .intercept   (intercept),
    .degenerate  (degenerate),
    .points_used (points_used)
);

`default_nettype wire
